### rtl/euler_ned_to_enu_quaternion_top_defines.svh
// Assertion macros shared by the checker.
`ifndef EULER_NED_TO_ENU_QUATERNION_TOP_DEFINES_SVH
`define EULER_NED_TO_ENU_QUATERNION_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ENQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ENQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/enq_pkg.sv
// Package: widths, constants and arithmetic helpers of the quaternion converter.
`default_nettype none
package enq_pkg;
    localparam int FRAC_BITS_DEF = 15;
    localparam logic [7:0] STATUS_ID = 8'h10;
    localparam logic signed [11:0] DECL_RESET = 12'sd107;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic signed [31:0] INV_SQRT2_Q30 = 32'sd759250125;
    localparam logic signed [31:0] Q_ONE = 32'sd1073741824;

    // PI_Q30 = 3600 * PI_DIV_Q + PI_DIV_R, so the scaling splits into a small remainder
    localparam logic [19:0] PI_DIV_Q = 20'(PI_Q30 / 32'd3600);
    localparam logic [10:0] PI_DIV_R = 11'(PI_Q30 % 32'd3600);
    localparam logic [21:0] RCP_3600 = 22'(((64'd1 << 33) + 64'd3599) / 64'd3600);

    // reciprocals ceil(2^s / d) for the series divisors, exact for n < 2^31
    localparam int RSH_72 = 38;
    localparam int RSH_90 = 38;
    localparam int RSH_42 = 37;
    localparam int RSH_56 = 37;
    localparam int RSH_20 = 36;
    localparam int RSH_30 = 36;
    localparam int RSH_6  = 34;
    localparam int RSH_12 = 35;
    localparam logic [31:0] RCP_72 = 32'(((64'd1 << RSH_72) + 64'd71) / 64'd72);
    localparam logic [31:0] RCP_90 = 32'(((64'd1 << RSH_90) + 64'd89) / 64'd90);
    localparam logic [31:0] RCP_42 = 32'(((64'd1 << RSH_42) + 64'd41) / 64'd42);
    localparam logic [31:0] RCP_56 = 32'(((64'd1 << RSH_56) + 64'd55) / 64'd56);
    localparam logic [31:0] RCP_20 = 32'(((64'd1 << RSH_20) + 64'd19) / 64'd20);
    localparam logic [31:0] RCP_30 = 32'(((64'd1 << RSH_30) + 64'd29) / 64'd30);
    localparam logic [31:0] RCP_6  = 32'(((64'd1 << RSH_6) + 64'd5) / 64'd6);
    localparam logic [31:0] RCP_12 = 32'(((64'd1 << RSH_12) + 64'd11) / 64'd12);

    typedef logic signed [31:0] q30_t;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
        logic [9:0] bb;
    } red_t;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
        q30_t       x;
    } arg_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
    } sc_t;

    // Q30 product of magnitudes rounded half up, sign reapplied
    function automatic q30_t mulq(input q30_t a, input q30_t b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic [33:0] r;
        ma = a[31] ? 32'(-a) : 32'(a);
        mb = b[31] ? 32'(-b) : 32'(b);
        p = ma * mb;
        r = 34'((p + 64'd536870912) >> 30);
        return (a[31] ^ b[31]) ? -q30_t'(r[31:0]) : q30_t'(r[31:0]);
    endfunction

    // floor(n / d) for 0 <= n < 2^31, m = ceil(2^s / d)
    function automatic q30_t div_rcp(input q30_t n, input logic [31:0] m, input int s);
        logic [63:0] p;
        p = 64'(n[30:0]) * 64'(m);
        return q30_t'(32'(p >> s));
    endfunction

    // wrap an angle in 0.05 degree units (|d| < 7200) to quadrant, swap flag, offset
    function automatic red_t wrap_angle(input logic signed [14:0] d);
        logic [12:0] a;
        logic [10:0] b;
        red_t r;
        a = d[14] ? 13'(d + 15'sd7200) : 13'(d);
        priority if (a >= 13'd5400)
        begin
            r.quad = 2'd3;
            b = 11'(a - 13'd5400);
        end
        else if (a >= 13'd3600)
        begin
            r.quad = 2'd2;
            b = 11'(a - 13'd3600);
        end
        else if (a >= 13'd1800)
        begin
            r.quad = 2'd1;
            b = 11'(a - 13'd1800);
        end
        else
        begin
            r.quad = 2'd0;
            b = 11'(a);
        end
        r.swap = (b > 11'd900);
        r.bb = r.swap ? 10'(11'd1800 - b) : 10'(b);
        return r;
    endfunction

    // round(bb * PI_Q30 / 3600), bb in [0,900]
    function automatic q30_t half_rad(input logic [9:0] bb);
        logic [29:0] hi;
        logic [20:0] n;
        logic [42:0] p;
        hi = 30'(bb) * 30'(PI_DIV_Q);
        n = 21'(bb) * 21'(PI_DIV_R) + 21'd1800;
        p = 43'(n) * 43'(RCP_3600);
        return q30_t'(32'(hi) + 32'(p[42:33]));
    endfunction

    function automatic logic [15:0] emit(input q30_t v, input int sh);
        logic [31:0] m;
        logic [31:0] half;
        logic [32:0] t;
        logic [15:0] o;
        m = v[31] ? 32'(-v) : 32'(v);
        half = (sh > 0) ? (32'd1 << (sh - 1)) : 32'd0;
        t = (33'(m) + 33'(half)) >> sh;
        o = (t > 33'd32767) ? 16'd32767 : t[15:0];
        return v[31] ? 16'(-o) : o;
    endfunction
endpackage
`default_nettype wire

### rtl/enq_stream_if.sv
// Valid/ready stream interfaces for input, result and configuration beats.
`default_nettype none
interface enq_in_if;
    logic valid;
    logic ready;
    logic [7:0] message_id;
    logic signed [12:0] yaw_decideg;
    logic signed [11:0] pitch_decideg;
    logic signed [11:0] roll_decideg;
    modport source (output valid, message_id, yaw_decideg, pitch_decideg, roll_decideg,
                    input ready);
    modport sink (input valid, message_id, yaw_decideg, pitch_decideg, roll_decideg,
                  output ready);
endinterface

interface enq_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface enq_cfg_if;
    logic valid;
    logic ready;
    logic signed [11:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/euler_ned_to_enu_quaternion_top.sv
// Top level: attitude angles to ENU quaternion, fully pipelined.
// Takes one beat per cycle while out_ch.ready is high; the rate is set only by
// the receiver. The pipe has 20 register stages. Stages: angle wrap, argument
// scaling, then per angle the sine and cosine series with a multiply stage and
// a reciprocal-divide stage for each Horner step, the quadrant fold, pair and
// triple products, the NED sums, the frame rotation, squares for the sign rule,
// sign application and output rounding.
// The whole pipe advances when the result register is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated. Beats with
// a message id other than 16 travel as bubbles and give no result.
// Declination is to be written over the cfg channel only while idle; the block does not enforce it. Reset value 107.
`default_nettype none
module euler_ned_to_enu_quaternion_top #(
    parameter int FRAC_BITS = enq_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    enq_in_if.sink    in_ch,
    enq_out_if.source out_ch,
    enq_cfg_if.sink   cfg
);
    localparam int SH = 30 - FRAC_BITS;
    localparam int NS = 19;   // stages before the output register

    logic signed [11:0] decl_reg;
    logic adv;
    logic [NS-1:0] v_reg;

    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decl_reg <= enq_pkg::DECL_RESET;
        else if (cfg.valid)
            decl_reg <= cfg.data;
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-2:0],
                      in_ch.valid && (in_ch.message_id == enq_pkg::STATUS_ID)};
    end

    // stage 1: wrap and quadrant; stage 2: argument scaling
    enq_pkg::red_t ra_reg [3];
    enq_pkg::arg_t a0_reg [3];
    // quadrant info must follow x through the series stages
    logic [1:0] qd_pipe_reg [3][10];
    logic sw_pipe_reg [3][10];
    // x and x2 per series stage
    enq_pkg::q30_t xs_reg [3][8];
    enq_pkg::q30_t x2s_reg [3][8];
    // sine and cosine Horner terms, multiply and divide stages alternate
    enq_pkg::q30_t tss_reg [3][9];
    enq_pkg::q30_t tcs_reg [3][9];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ra_reg[0] <= enq_pkg::wrap_angle(15'(in_ch.yaw_decideg) - 15'(decl_reg));
            ra_reg[1] <= enq_pkg::wrap_angle(15'(in_ch.pitch_decideg));
            ra_reg[2] <= enq_pkg::wrap_angle(15'(in_ch.roll_decideg));
            for (int k = 0; k < 3; k++)
            begin
                a0_reg[k].quad <= ra_reg[k].quad;
                a0_reg[k].swap <= ra_reg[k].swap;
                a0_reg[k].x <= enq_pkg::half_rad(ra_reg[k].bb);
                qd_pipe_reg[k][0] <= a0_reg[k].quad;
                sw_pipe_reg[k][0] <= a0_reg[k].swap;
                for (int j = 1; j < 10; j++)
                begin
                    qd_pipe_reg[k][j] <= qd_pipe_reg[k][j-1];
                    sw_pipe_reg[k][j] <= sw_pipe_reg[k][j-1];
                end
                xs_reg[k][0] <= a0_reg[k].x;
                x2s_reg[k][0] <= enq_pkg::mulq(a0_reg[k].x, a0_reg[k].x);
                for (int j = 1; j < 8; j++)
                begin
                    xs_reg[k][j] <= xs_reg[k][j-1];
                    x2s_reg[k][j] <= x2s_reg[k][j-1];
                end
                // initial terms
                tss_reg[k][0] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(x2s_reg[k][0], enq_pkg::RCP_72, enq_pkg::RSH_72);
                tcs_reg[k][0] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(x2s_reg[k][0], enq_pkg::RCP_90, enq_pkg::RSH_90);
                // Horner steps
                tss_reg[k][1] <= enq_pkg::mulq(x2s_reg[k][1], tss_reg[k][0]);
                tcs_reg[k][1] <= enq_pkg::mulq(x2s_reg[k][1], tcs_reg[k][0]);
                tss_reg[k][2] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(tss_reg[k][1], enq_pkg::RCP_42, enq_pkg::RSH_42);
                tcs_reg[k][2] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(tcs_reg[k][1], enq_pkg::RCP_56, enq_pkg::RSH_56);
                tss_reg[k][3] <= enq_pkg::mulq(x2s_reg[k][3], tss_reg[k][2]);
                tcs_reg[k][3] <= enq_pkg::mulq(x2s_reg[k][3], tcs_reg[k][2]);
                tss_reg[k][4] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(tss_reg[k][3], enq_pkg::RCP_20, enq_pkg::RSH_20);
                tcs_reg[k][4] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(tcs_reg[k][3], enq_pkg::RCP_30, enq_pkg::RSH_30);
                tss_reg[k][5] <= enq_pkg::mulq(x2s_reg[k][5], tss_reg[k][4]);
                tcs_reg[k][5] <= enq_pkg::mulq(x2s_reg[k][5], tcs_reg[k][4]);
                tss_reg[k][6] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(tss_reg[k][5], enq_pkg::RCP_6, enq_pkg::RSH_6);
                tcs_reg[k][6] <= enq_pkg::Q_ONE -
                    enq_pkg::div_rcp(tcs_reg[k][5], enq_pkg::RCP_12, enq_pkg::RSH_12);
                // sine = x * t; last cosine step divides by two
                tss_reg[k][7] <= enq_pkg::mulq(xs_reg[k][7], tss_reg[k][6]);
                tcs_reg[k][7] <= enq_pkg::mulq(x2s_reg[k][7], tcs_reg[k][6]);
                tss_reg[k][8] <= tss_reg[k][7];
                tcs_reg[k][8] <= enq_pkg::Q_ONE - (tcs_reg[k][7] >>> 1);
            end
        end
    end

    // quadrant fold from the last series stage
    enq_pkg::sc_t sc [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            enq_pkg::q30_t s0;
            enq_pkg::q30_t c0;
            s0 = sw_pipe_reg[k][9] ? tcs_reg[k][8] : tss_reg[k][8];
            c0 = sw_pipe_reg[k][9] ? tss_reg[k][8] : tcs_reg[k][8];
            unique case (qd_pipe_reg[k][9])
                2'd0: begin sc[k].s = s0; sc[k].c = c0; end
                2'd1: begin sc[k].s = c0; sc[k].c = -s0; end
                2'd2: begin sc[k].s = -s0; sc[k].c = -c0; end
                default: begin sc[k].s = -c0; sc[k].c = s0; end
            endcase
        end
    end

    // fold registered; then pair products; then triples
    enq_pkg::sc_t y9_reg, p9_reg, r9_reg;
    enq_pkg::q30_t cycp_reg, sysp_reg, cysp_reg, sycp_reg, cr10_reg, sr10_reg;
    enq_pkg::q30_t t_reg [8];
    enq_pkg::q30_t nw_reg, nx_reg, ny_reg, nz_reg;
    enq_pkg::q30_t ew_reg, ex_reg, ey_reg, ez_reg;
    enq_pkg::q30_t w2_reg, x2q_reg, y2_reg, z2_reg;
    enq_pkg::q30_t sw_reg, sx_reg, sy_reg, sz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y9_reg <= sc[0];
            p9_reg <= sc[1];
            r9_reg <= sc[2];
            cycp_reg <= enq_pkg::mulq(y9_reg.c, p9_reg.c);
            sysp_reg <= enq_pkg::mulq(y9_reg.s, p9_reg.s);
            cysp_reg <= enq_pkg::mulq(y9_reg.c, p9_reg.s);
            sycp_reg <= enq_pkg::mulq(y9_reg.s, p9_reg.c);
            cr10_reg <= r9_reg.c;
            sr10_reg <= r9_reg.s;
            t_reg[0] <= enq_pkg::mulq(cycp_reg, cr10_reg);
            t_reg[1] <= enq_pkg::mulq(sysp_reg, sr10_reg);
            t_reg[2] <= enq_pkg::mulq(cycp_reg, sr10_reg);
            t_reg[3] <= enq_pkg::mulq(sysp_reg, cr10_reg);
            t_reg[4] <= enq_pkg::mulq(cysp_reg, cr10_reg);
            t_reg[5] <= enq_pkg::mulq(sycp_reg, sr10_reg);
            t_reg[6] <= enq_pkg::mulq(sycp_reg, cr10_reg);
            t_reg[7] <= enq_pkg::mulq(cysp_reg, sr10_reg);
            nw_reg <= t_reg[0] + t_reg[1];
            nx_reg <= t_reg[2] - t_reg[3];
            ny_reg <= t_reg[4] + t_reg[5];
            nz_reg <= t_reg[6] - t_reg[7];
            ew_reg <= enq_pkg::mulq(enq_pkg::INV_SQRT2_Q30, ny_reg - nx_reg);
            ex_reg <= enq_pkg::mulq(enq_pkg::INV_SQRT2_Q30, nw_reg + nz_reg);
            ey_reg <= enq_pkg::mulq(enq_pkg::INV_SQRT2_Q30, nz_reg - nw_reg);
            ez_reg <= -enq_pkg::mulq(enq_pkg::INV_SQRT2_Q30, nx_reg + ny_reg);
            w2_reg <= enq_pkg::mulq(ew_reg, ew_reg);
            x2q_reg <= enq_pkg::mulq(ex_reg, ex_reg);
            y2_reg <= enq_pkg::mulq(ey_reg, ey_reg);
            z2_reg <= enq_pkg::mulq(ez_reg, ez_reg);
            sw_reg <= ew_reg;
            sx_reg <= ex_reg;
            sy_reg <= ey_reg;
            sz_reg <= ez_reg;
        end
    end

    // sign rule on registered squares
    logic neg;
    always_comb
    begin
        enq_pkg::q30_t pick;
        enq_pkg::q30_t best;
        pick = sx_reg;
        best = x2q_reg;
        if (y2_reg > best)
        begin
            pick = sy_reg;
            best = y2_reg;
        end
        if (z2_reg > best)
            pick = sz_reg;
        if (w2_reg > (enq_pkg::Q_ONE >>> 2))
            pick = sw_reg;
        neg = pick[31];
    end

    // stage: signed components; then output register with rounding
    enq_pkg::q30_t fw_reg, fx_reg, fy_reg, fz_reg;
    logic out_valid_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fw_reg <= neg ? -sw_reg : sw_reg;
            fx_reg <= neg ? -sx_reg : sx_reg;
            fy_reg <= neg ? -sy_reg : sy_reg;
            fz_reg <= neg ? -sz_reg : sz_reg;
            qx_reg <= enq_pkg::emit(fx_reg, SH);
            qy_reg <= enq_pkg::emit(fy_reg, SH);
            qz_reg <= enq_pkg::emit(fz_reg, SH);
            qw_reg <= enq_pkg::emit(fw_reg, SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[NS-1];
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.quat_x = qx_reg;
    assign out_ch.quat_y = qy_reg;
    assign out_ch.quat_z = qz_reg;
    assign out_ch.quat_w = qw_reg;
endmodule
`default_nettype wire

### rtl/enq_checker.sv
// Port-level checker for the quaternion converter, bound to the top level.
`default_nettype none
`include "euler_ned_to_enu_quaternion_top_defines.svh"
module enq_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [63:0] out_data
);
    `ENQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
    `ENQ_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")
    `ENQ_ASSERT_IMPL(a_ready_take, clk, rst_n, out_valid && out_ready, in_ready, "input blocked while result taken")
    `ENQ_ASSERT_NEXT(a_reset_empty, clk, rst_n, $rose(rst_n), !out_valid, "result right after reset")
endmodule

bind euler_ned_to_enu_quaternion_top enq_checker u_enq_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data({out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w})
);
`default_nettype wire

### dv/enq_attitude_scoreboard.sv
// Scoreboard class: predicts ENU quaternions from attitude beats and checks results.
class enq_attitude_scoreboard;
    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } quat_t;

    quat_t pending_quats[$];
    logic signed [11:0] declination;
    int errors;

    function new();
        declination = enq_pkg::DECL_RESET;
        errors = 0;
    endfunction

    // Q30 product of magnitudes, rounded half up, sign of the exact product
    static function longint qmul(longint a, longint b);
        longint ma;
        longint mb;
        longint r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r = (ma * mb + (longint'(1) << 29)) >>> 30;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    static function longint taylor_sin(longint x);
        longint x2;
        longint t;
        x2 = qmul(x, x);
        t = (longint'(1) << 30) - x2 / 72;
        t = (longint'(1) << 30) - qmul(x2, t) / 42;
        t = (longint'(1) << 30) - qmul(x2, t) / 20;
        t = (longint'(1) << 30) - qmul(x2, t) / 6;
        return qmul(x, t);
    endfunction

    static function longint taylor_cos(longint x);
        longint x2;
        longint t;
        x2 = qmul(x, x);
        t = (longint'(1) << 30) - x2 / 90;
        t = (longint'(1) << 30) - qmul(x2, t) / 56;
        t = (longint'(1) << 30) - qmul(x2, t) / 30;
        t = (longint'(1) << 30) - qmul(x2, t) / 12;
        t = (longint'(1) << 30) - qmul(x2, t) / 2;
        return t;
    endfunction

    static function longint half_rad(longint b);
        return (b * 64'd3373259426 + 1800) / 3600;
    endfunction

    // half-angle sine/cosine of d units of 0.05 degree
    static function void half_sin_cos(longint d, output longint s, output longint c);
        longint a;
        longint b;
        longint s0;
        longint c0;
        a = d % 7200;
        if (a < 0)
            a += 7200;
        b = a % 1800;
        if (b <= 900)
        begin
            s0 = taylor_sin(half_rad(b));
            c0 = taylor_cos(half_rad(b));
        end
        else
        begin
            s0 = taylor_cos(half_rad(1800 - b));
            c0 = taylor_sin(half_rad(1800 - b));
        end
        case (a / 1800)
            0: begin s = s0;  c = c0;  end
            1: begin s = c0;  c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endfunction

    static function logic [15:0] to_q15(longint v);
        longint m;
        m = (((v < 0) ? -v : v) + (longint'(1) << 14)) >>> 15;
        if (m > 32767)
            m = 32767;
        return (v < 0) ? 16'(-m) : 16'(m);
    endfunction

    function void note_beat(logic [7:0] id, logic signed [12:0] yaw,
                            logic signed [11:0] pitch, logic signed [11:0] roll);
        longint sy, cy, sp, cp, sr, cr;
        longint nw, nx, ny, nz, ew, ex, ey, ez;
        longint w2, x2, y2, z2, best, pick;
        longint h;
        quat_t q;
        if (id != enq_pkg::STATUS_ID)
            return;
        h = enq_pkg::INV_SQRT2_Q30;
        half_sin_cos(longint'(yaw) - longint'(declination), sy, cy);
        half_sin_cos(longint'(pitch), sp, cp);
        half_sin_cos(longint'(roll), sr, cr);
        nw = qmul(qmul(cy, cp), cr) + qmul(qmul(sy, sp), sr);
        nx = qmul(qmul(cy, cp), sr) - qmul(qmul(sy, sp), cr);
        ny = qmul(qmul(cy, sp), cr) + qmul(qmul(sy, cp), sr);
        nz = qmul(qmul(sy, cp), cr) - qmul(qmul(cy, sp), sr);
        ew = qmul(h, ny - nx);
        ex = qmul(h, nw + nz);
        ey = qmul(h, nz - nw);
        ez = -qmul(h, nx + ny);
        w2 = qmul(ew, ew);
        x2 = qmul(ex, ex);
        y2 = qmul(ey, ey);
        z2 = qmul(ez, ez);
        if (w2 > (longint'(1) << 28))
            pick = ew;
        else
        begin
            pick = ex;
            best = x2;
            if (y2 > best)
            begin
                pick = ey;
                best = y2;
            end
            if (z2 > best)
                pick = ez;
        end
        if (pick < 0)
        begin
            ew = -ew; ex = -ex; ey = -ey; ez = -ez;
        end
        q.qx = to_q15(ex);
        q.qy = to_q15(ey);
        q.qz = to_q15(ez);
        q.qw = to_q15(ew);
        pending_quats.push_back(q);
    endfunction

    function void check_result(quat_t got);
        quat_t want;
        if (pending_quats.size() == 0)
        begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d",
                     $time, got.qx, got.qy, got.qz, got.qw);
            errors++;
            return;
        end
        want = pending_quats.pop_front();
        if (got.qx !== want.qx)
            $display("%0t: quat_x expected %0d actual %0d", $time, want.qx, got.qx);
        if (got.qy !== want.qy)
            $display("%0t: quat_y expected %0d actual %0d", $time, want.qy, got.qy);
        if (got.qz !== want.qz)
            $display("%0t: quat_z expected %0d actual %0d", $time, want.qz, got.qz);
        if (got.qw !== want.qw)
            $display("%0t: quat_w expected %0d actual %0d", $time, want.qw, got.qw);
        if (got !== want)
            errors++;
    endfunction
endclass

### dv/tb.sv
// Testbench top: drives attitude beats and declination writes, checks quaternions.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 20;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    enq_in_if  in_ch();
    enq_out_if out_ch();
    enq_cfg_if cfg();

    euler_ned_to_enu_quaternion_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    enq_attitude_scoreboard quat_board = new();

    longint cycle_count = 0;
    bit calm_phase = 0;        // no idling on either side while set
    int hold_off_cycles = 0;   // receiver long stall, counted down below

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: sample at rising edge, change ready at falling edge
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            quat_board.check_result({out_ch.quat_x, out_ch.quat_y,
                                     out_ch.quat_z, out_ch.quat_w});

    initial
    begin
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    // one attitude beat; random gaps before it. Returns at a falling edge with
    // valid still up; the next beat or drain_results decides what valid does next.
    task automatic send_attitude(logic [7:0] id, logic signed [12:0] yaw,
                                 logic signed [11:0] pitch, logic signed [11:0] roll);
        while (!calm_phase && $urandom_range(99) < 24)
        begin
            in_ch.valid <= 0;
            @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.message_id <= id;
        in_ch.yaw_decideg <= yaw;
        in_ch.pitch_decideg <= pitch;
        in_ch.roll_decideg <= roll;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        quat_board.note_beat(id, yaw, pitch, roll);
        @(negedge clk);
    endtask

    task automatic send_status(int yaw, int pitch, int roll);
        send_attitude(enq_pkg::STATUS_ID, 13'(yaw), 12'(pitch), 12'(roll));
    endtask

    // stop offering, wait for every expected quaternion, then let bubbles drain
    task automatic drain_results();
        in_ch.valid <= 0;
        while (quat_board.pending_quats.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_declination(int decl);
        drain_results();
        cfg.valid <= 1;
        cfg.data <= 12'(decl);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        quat_board.declination = 12'(decl);
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    // random beats: mostly status messages with in-range angles
    task automatic random_beats(int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_attitude(8'($urandom), 13'($urandom), 12'($urandom), 12'($urandom));
            else if (pick < 14)
                send_status($urandom, $urandom, $urandom);  // full bit patterns
            else
                send_status(int'($urandom_range(7200)) - 3600,
                            int'($urandom_range(3600)) - 1800,
                            int'($urandom_range(3600)) - 1800);
        end
    endtask

    initial
    begin
        in_ch.valid = 0;
        in_ch.message_id = 0;
        in_ch.yaw_decideg = 0;
        in_ch.pitch_decideg = 0;
        in_ch.roll_decideg = 0;
        cfg.valid = 0;
        cfg.data = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, quadrant edges, non-status ids, at reset declination
        send_status(0, 0, 0);
        send_status(3600, 1800, 1800);
        send_status(-3600, -1800, -1800);
        send_status(900, 0, 0);
        send_status(0, 900, 0);
        send_status(0, 0, 900);
        send_status(1800, -900, 450);
        send_status(-2700, 1350, -1350);
        send_status(4095, 2047, 2047);      // wrapped beyond range
        send_status(-4096, -2048, -2048);
        send_status(107, 0, 1800);          // yaw cancels declination
        send_status(1807, 0, 0);            // w near zero, axis choice
        send_status(107, 1800, 0);
        send_attitude(8'h00, 13'sd0, 12'sd0, 12'sd0);
        send_attitude(8'hFF, 13'sd100, 12'sd100, 12'sd100);
        send_attitude(8'h11, 13'sd100, 12'sd100, 12'sd100);
        send_attitude(8'h0F, 13'sd100, 12'sd100, 12'sd100);

        write_declination(-1800);
        send_status(0, 0, 0);
        send_status(-1800, 0, 0);
        write_declination(1800);
        send_status(1800, 900, -900);
        write_declination(-2048);           // most negative code
        send_status(0, 0, 0);
        write_declination(2047);
        send_status(0, 0, 0);

        // calm stretch, no idling either side
        write_declination(0);
        calm_phase = 1;
        random_beats(200);
        calm_phase = 0;

        // long receiver hold-off while beats keep coming, so the pipe backs up
        hold_off_cycles = 120;
        random_beats(150);
        drain_results();   // sender pauses until everything is back

        write_declination(107);
        random_beats(400);
        write_declination($urandom_range(3600) - 1800);
        random_beats(400);
        write_declination($urandom_range(3600) - 1800);
        hold_off_cycles = 80;
        random_beats(250);

        drain_results();
        if (quat_board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
